// ----- rtl/scp_pkg.sv -----
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the serial command line parser
// Value format, job record passed from the line front end to the back end,
// result kind codes and the power-of-ten table used by the fraction divider.
// ----------------------------------------------------------------------------
package scp_pkg;

  // value format
  localparam int VALUE_BITS      = 48;
  localparam int KEEP_DIGITS     = 24;
  localparam int DCNT_W          = $clog2(KEEP_DIGITS + 1);
  // 10^24 < 2^80, so every kept fraction fits in 80 bits
  localparam int FRAC_W          = 80;

  // defaults for the top level parameters and the queue depth
  localparam int LINE_CAPACITY_DEF = 32;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int QUEUE_DEPTH       = 2;

  // reset value of the delimiter register (space)
  localparam logic [7:0] DELIM_RESET = 8'd32;

  // result kind codes
  localparam logic KIND_HELLO   = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  typedef logic [FRAC_W-1:0] frac_t;

  // one judged line, handed from the front end to the back end
  typedef struct packed {
    logic                  kind;
    logic [7:0]            letter;
    logic                  negative;
    logic                  overflow;
    logic [DCNT_W-1:0]     frac_cnt;
    frac_t                 frac_num;
    logic [VALUE_BITS-1:0] int_scaled;
  } job_t;

  // 10^n for n kept fraction digits
  function automatic frac_t pow10(input logic [DCNT_W-1:0] n);
    frac_t p;
    case (n)
      5'd0:    p = 80'd1;
      5'd1:    p = 80'd10;
      5'd2:    p = 80'd100;
      5'd3:    p = 80'd1_000;
      5'd4:    p = 80'd10_000;
      5'd5:    p = 80'd100_000;
      5'd6:    p = 80'd1_000_000;
      5'd7:    p = 80'd10_000_000;
      5'd8:    p = 80'd100_000_000;
      5'd9:    p = 80'd1_000_000_000;
      5'd10:   p = 80'd10_000_000_000;
      5'd11:   p = 80'd100_000_000_000;
      5'd12:   p = 80'd1_000_000_000_000;
      5'd13:   p = 80'd10_000_000_000_000;
      5'd14:   p = 80'd100_000_000_000_000;
      5'd15:   p = 80'd1_000_000_000_000_000;
      5'd16:   p = 80'd10_000_000_000_000_000;
      5'd17:   p = 80'd100_000_000_000_000_000;
      5'd18:   p = 80'd1_000_000_000_000_000_000;
      5'd19:   p = 80'd10_000_000_000_000_000_000;
      5'd20:   p = 80'd100_000_000_000_000_000_000;
      5'd21:   p = 80'd1_000_000_000_000_000_000_000;
      5'd22:   p = 80'd10_000_000_000_000_000_000_000;
      5'd23:   p = 80'd100_000_000_000_000_000_000_000;
      5'd24:   p = 80'd1_000_000_000_000_000_000_000_000;
      default: p = 80'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/scp_if.sv -----
// ----------------------------------------------------------------------------
// scp channel interfaces
// Valid/ready channels of the parser: received bytes, parse results and
// delimiter register writes. A transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// received byte channel
interface scp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// parse result channel
interface scp_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 result_kind;
  logic [7:0]                           command_letter;
  logic signed [scp_pkg::VALUE_BITS-1:0] command_value;
  logic                                 value_saturated;

  modport source (output valid, output result_kind, output command_letter,
                  output command_value, output value_saturated, input ready);
  modport sink   (input valid, input result_kind, input command_letter,
                  input command_value, input value_saturated, output ready);
endinterface

// delimiter register write channel
interface scp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] delimiter_char;

  modport source (output valid, output delimiter_char, input ready);
  modport sink   (input valid, input delimiter_char, output ready);
endinterface

// ----- rtl/serial_command_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser_core: serial command line parser
// Collects received bytes into lines, answers HELLO and turns command lines
// into a letter and a signed fixed point value.
// ----------------------------------------------------------------------------
// The front end takes one received byte per cycle. A line terminator is held
// off only while the two-entry job queue is full. Each command line then
// passes through the back end's restoring divider, producing one fraction
// bit per cycle, while a HELLO line skips it; the back end takes a new job
// only once it has handed the last one to its output register, so short
// command lines are paced by the divider. Results leave through an
// output register, so a stalled result holds off only line terminators, and
// only once the queue behind it has filled. The delimiter register resets to
// space and may be rewritten while idle.
module serial_command_line_parser_core #(
  parameter int LINE_CAPACITY = scp_pkg::LINE_CAPACITY_DEF,
  parameter int FRAC_BITS     = scp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scp_byte_if.sink     in_ch,
  scp_result_if.source out_ch,
  scp_cfg_if.sink      cfg_ch
);

  logic          push_valid, push_ready;
  scp_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  scp_pkg::job_t pop_job;

  // line collection and classification
  scp_front #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // decoupling queue
  scp_queue #(
    .DEPTH (scp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // value conversion and result output
  scp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/scp_queue.sv -----
// ----------------------------------------------------------------------------
// scp_queue: job queue between front end and back end
// Small register FIFO of judged lines; lets either side stall on its own.
// ----------------------------------------------------------------------------
module scp_queue #(
  parameter int DEPTH = scp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  scp_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output scp_pkg::job_t pop_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  scp_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  // handshake and pointer update
  always_comb begin
    push_ready = (count_r != CNT_FULL);
    pop_valid  = (count_r != '0);
    pop_job    = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/scp_front.sv -----
// ----------------------------------------------------------------------------
// scp_front: line collector and classifier
// Takes one byte per cycle (a line terminator waits while the job queue is full),
// tracks the running line state (length, HELLO match, delimiter, number scan) and queues a job for every judged line.
// ----------------------------------------------------------------------------
module scp_front #(
  parameter int LINE_CAPACITY = scp_pkg::LINE_CAPACITY_DEF,
  parameter int FRAC_BITS     = scp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  scp_byte_if.sink      in_ch,
  scp_cfg_if.sink       cfg_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output scp_pkg::job_t push_job
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam int INT_W = scp_pkg::VALUE_BITS - FRAC_BITS;
  localparam int ACC_W = INT_W + 4;
  localparam int FW    = scp_pkg::FRAC_W;
  localparam int DW    = scp_pkg::DCNT_W;

  // integer part is pinned here once it must overflow
  localparam logic [ACC_W-1:0] INT_CAP  = ACC_W'((64'd1 << (INT_W - 1)) + 64'd1);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [LEN_W-1:0] HELLO_LEN = LEN_W'(5);
  localparam logic [DW-1:0]    KEEP     = DW'(scp_pkg::KEEP_DIGITS);

  // number scan phases
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  function automatic logic [7:0] hello_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h45;
      3'd2:    ch = 8'h4C;
      3'd3:    ch = 8'h4C;
      3'd4:    ch = 8'h4F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [7:0]       delim_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             zero_r, zero_nxt;
  logic             hello_r, hello_nxt;
  logic [7:0]       first_r, first_nxt;
  logic             dfound_r, dfound_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [INT_W-1:0] mag_r, mag_nxt;
  logic [DW-1:0]    fcnt_r, fcnt_nxt;
  scp_pkg::frac_t   fnum_r, fnum_nxt;
  logic             ovf_r, ovf_nxt;

  logic [7:0]       c;
  logic             is_term, is_digit, is_ws, accept, line_empty, hello_hit, line_clr;
  logic [3:0]       dig;
  logic [ACC_W-1:0] mag_ext, int_acc;
  logic             int_sat;
  logic [INT_W-1:0] int_new;
  scp_pkg::frac_t   frac_new;

  // byte classification and handshake
  always_comb begin
    c          = in_ch.rx_byte;
    is_term    = (c == CHAR_LF) || (c == CHAR_CR);
    is_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_ws      = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    dig        = c[3:0];
    in_ch.ready = !is_term || push_ready;
    accept     = in_ch.valid && in_ch.ready;
    line_empty = (len_r == '0);
    hello_hit  = hello_r && (zero_r || (len_r == HELLO_LEN));
    push_valid = in_ch.valid && is_term && !line_empty && (hello_hit || dfound_r);
  end

  // job record for the back end
  always_comb begin
    push_job.kind       = hello_hit ? scp_pkg::KIND_HELLO : scp_pkg::KIND_COMMAND;
    push_job.letter     = first_r;
    push_job.negative   = neg_r;
    push_job.overflow   = ovf_r;
    push_job.frac_cnt   = fcnt_r;
    push_job.frac_num   = fnum_r;
    push_job.int_scaled = {mag_r, {FRAC_BITS{1'b0}}};
  end

  // digit accumulation, times ten plus digit
  always_comb begin
    mag_ext  = {4'b0000, mag_r};
    int_acc  = (mag_ext << 3) + (mag_ext << 1) + ACC_W'(dig);
    int_sat  = (int_acc >= INT_CAP);
    int_new  = int_sat ? INT_CAP[INT_W-1:0] : int_acc[INT_W-1:0];
    frac_new = (fnum_r << 3) + (fnum_r << 1) + FW'(dig);
  end

  // line state update
  always_comb begin
    len_nxt    = len_r;
    zero_nxt   = zero_r;
    hello_nxt  = hello_r;
    first_nxt  = first_r;
    dfound_nxt = dfound_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    fcnt_nxt   = fcnt_r;
    fnum_nxt   = fnum_r;
    ovf_nxt    = ovf_r;
    line_clr   = 1'b0;
    if (accept) begin
      if (is_term) begin
        line_clr = !line_empty;
      end else if (len_r == LEN_LAST) begin
        // full line: empty it and drop the byte
        line_clr = 1'b1;
      end else begin
        len_nxt = len_r + 1'b1;
        if (!zero_r) begin
          if (c == CHAR_NUL) begin
            zero_nxt = 1'b1;
            if (len_r < HELLO_LEN) begin
              hello_nxt = 1'b0;
            end
          end else begin
            if (line_empty) begin
              first_nxt = c;
            end
            if ((len_r >= HELLO_LEN) || (c != hello_char(len_r[2:0]))) begin
              hello_nxt = 1'b0;
            end
            if (!dfound_r) begin
              if (c == delim_r) begin
                dfound_nxt = 1'b1;
              end
            end else begin
              // number scan after the first delimiter
              case (phase_r)
                PH_SKIP: begin
                  if (is_ws) begin
                    phase_nxt = PH_SKIP;
                  end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                    neg_nxt   = (c == CHAR_MINUS);
                    phase_nxt = PH_INT;
                  end else if (is_digit) begin
                    mag_nxt   = int_new;
                    ovf_nxt   = ovf_r | int_sat;
                    phase_nxt = PH_INT;
                  end else if (c == CHAR_POINT) begin
                    phase_nxt = PH_FRAC;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                PH_INT: begin
                  if (is_digit) begin
                    mag_nxt = int_new;
                    ovf_nxt = ovf_r | int_sat;
                  end else if (c == CHAR_POINT) begin
                    phase_nxt = PH_FRAC;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                PH_FRAC: begin
                  if (is_digit) begin
                    if (fcnt_r < KEEP) begin
                      fnum_nxt = frac_new;
                      fcnt_nxt = fcnt_r + 1'b1;
                    end
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                default: begin
                  phase_nxt = phase_r;
                end
              endcase
            end
          end
        end
      end
    end
    // start a fresh line
    if (line_clr) begin
      len_nxt    = '0;
      zero_nxt   = 1'b0;
      hello_nxt  = 1'b1;
      first_nxt  = '0;
      dfound_nxt = 1'b0;
      phase_nxt  = PH_SKIP;
      neg_nxt    = 1'b0;
      mag_nxt    = '0;
      fcnt_nxt   = '0;
      fnum_nxt   = '0;
      ovf_nxt    = 1'b0;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= scp_pkg::DELIM_RESET;
      len_r    <= '0;
      zero_r   <= 1'b0;
      hello_r  <= 1'b1;
      first_r  <= '0;
      dfound_r <= 1'b0;
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      fcnt_r   <= '0;
      fnum_r   <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        delim_r <= cfg_ch.delimiter_char;
      end
      len_r    <= len_nxt;
      zero_r   <= zero_nxt;
      hello_r  <= hello_nxt;
      first_r  <= first_nxt;
      dfound_r <= dfound_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      fcnt_r   <= fcnt_nxt;
      fnum_r   <= fnum_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/scp_back.sv -----
// ----------------------------------------------------------------------------
// scp_back: value builder
// Converts the decimal fraction of a command to FRAC_BITS binary bits with a
// restoring divider (one bit per cycle), adds the integer part, saturates
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module scp_back #(
  parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  scp_pkg::job_t pop_job,
  scp_result_if.source  out_ch
);

  localparam int VB    = scp_pkg::VALUE_BITS;
  localparam int MAG_W = VB + 1;
  localparam int FW    = scp_pkg::FRAC_W;
  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << (VB - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  scp_pkg::job_t        job_r, job_nxt;
  scp_pkg::frac_t       rem_r, rem_nxt;
  scp_pkg::frac_t       div_r, div_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [7:0]           out_letter_r, out_letter_nxt;
  logic [VB-1:0]        out_value_r, out_value_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic [FW:0]          rem2, rem_sub;
  logic                 ge;
  logic [MAG_W-1:0]     mag_sum, mag_clip;
  logic                 clip;
  logic [VB-1:0]        value;
  logic                 out_load;

  // one restoring division step
  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = (rem2 >= {1'b0, div_r});
    rem_sub = rem2 - {1'b0, div_r};
  end

  // integer plus fraction, clamp to the signed range
  always_comb begin
    mag_sum = {1'b0, job_r.int_scaled} + MAG_W'(quo_r);
    if (job_r.negative) begin
      clip     = (mag_sum > MAG_LIMIT);
      mag_clip = clip ? MAG_LIMIT : mag_sum;
      value    = VB'(MAG_W'(0) - mag_clip);
    end else begin
      clip     = (mag_sum > (MAG_LIMIT - 1'b1));
      mag_clip = clip ? (MAG_LIMIT - 1'b1) : mag_sum;
      value    = mag_clip[VB-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    pop_ready      = (state_r == S_IDLE);
    out_load       = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_letter_nxt = out_letter_r;
    out_value_nxt  = out_value_r;
    out_sat_nxt    = out_sat_r;
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          job_nxt   = pop_job;
          rem_nxt   = pop_job.frac_num;
          div_nxt   = scp_pkg::pow10(pop_job.frac_cnt);
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(FRAC_BITS - 1);
          state_nxt = (pop_job.kind == scp_pkg::KIND_COMMAND) ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? rem_sub[FW-1:0] : rem2[FW-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // output register
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (job_r.kind == scp_pkg::KIND_HELLO) begin
        out_kind_nxt   = scp_pkg::KIND_HELLO;
        out_letter_nxt = '0;
        out_value_nxt  = '0;
        out_sat_nxt    = 1'b0;
      end else begin
        out_kind_nxt   = scp_pkg::KIND_COMMAND;
        out_letter_nxt = job_r.letter;
        out_value_nxt  = value;
        out_sat_nxt    = clip | job_r.overflow;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_kind_r;
  assign out_ch.command_letter  = out_letter_r;
  assign out_ch.command_value   = out_value_r;
  assign out_ch.value_saturated = out_sat_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_letter_r <= out_letter_nxt;
    out_value_r  <= out_value_nxt;
    out_sat_r    <= out_sat_nxt;
  end

endmodule

// ----- tb/serial_command_line_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser_core_test: self-checking bench for the parser
// Streams received bytes into the parser and keeps a line-level model of its
// own. Every line terminator that should produce a handshake or a command
// queues the expected reply, and each reply transfer is checked against the
// oldest one. Covers directed corner cases (handshake text, number syntax,
// full lines, zero bytes, delimiter settings), output back-pressure and a
// long random run with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module serial_command_line_parser_core_test;

  localparam int LINE_CAP      = scp_pkg::LINE_CAPACITY_DEF;
  localparam int FRAC_BITS     = scp_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_BYTES  = 620;
  localparam int HOLD_OFF      = 400;
  localparam int WATCHDOG      = 400000;

  // byte codes the parser reacts to
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [39:0] HELLO_TEXT = "HELLO";

  typedef enum logic [1:0] {NUM_SKIP_WS, NUM_INT, NUM_FRAC, NUM_DONE} num_phase_t;

  typedef struct {
    logic                           kind;
    logic [7:0]                     letter;
    logic [scp_pkg::VALUE_BITS-1:0] value;
    logic                           saturated;
  } reply_t;

  logic clk;
  logic rst_n;

  scp_byte_if   in_if ();
  scp_result_if out_if ();
  scp_cfg_if    cfg_if ();

  serial_command_line_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // expected replies, oldest first
  reply_t awaited_replies[$];
  int     fail_count;
  int     random_bytes_sent;

  // sender burst shaping and receiver hold-off request
  bit gaps_on;
  int burst_left;
  int stall_request;

  // line model state
  logic [7:0]   delim_reg;
  int           line_len;
  bit           zero_seen;
  bit           hello_ok;
  logic [7:0]   lead_byte;
  bit           delim_hit;
  num_phase_t   num_phase;
  bit           negative;
  logic [63:0]  int_mag;
  bit           int_overflow;
  int           frac_cnt;
  logic [127:0] frac_num;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_line();
    line_len     = 0;
    zero_seen    = 0;
    hello_ok     = 1;
    lead_byte    = 8'd0;
    delim_hit    = 0;
    num_phase    = NUM_SKIP_WS;
    negative     = 0;
    int_mag      = 64'd0;
    int_overflow = 0;
    frac_cnt     = 0;
    frac_num     = 128'd0;
  endfunction

  function automatic logic [127:0] ten_to(input int n);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // integer part is pinned just above the largest representable value
  function automatic void add_int_digit(input logic [7:0] c);
    logic [63:0] cap;
    logic [63:0] v;
    cap = (64'd1 << (scp_pkg::VALUE_BITS - 1 - FRAC_BITS)) + 64'd1;
    v = int_mag * 10 + (c - CH_ZERO);
    if (v >= cap) begin
      v = cap;
      int_overflow = 1;
    end
    int_mag = v;
  endfunction

  // atof-style scan after the first delimiter
  function automatic void scan_number(input logic [7:0] c);
    bit is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (num_phase)
      NUM_SKIP_WS: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
        if (c == CH_PLUS || c == CH_MINUS) begin
          negative  = (c == CH_MINUS);
          num_phase = NUM_INT;
        end else if (is_digit) begin
          add_int_digit(c);
          num_phase = NUM_INT;
        end else if (c == CH_POINT) begin
          num_phase = NUM_FRAC;
        end else begin
          num_phase = NUM_DONE;
        end
      end
      NUM_INT: begin
        if (is_digit) add_int_digit(c);
        else if (c == CH_POINT) num_phase = NUM_FRAC;
        else num_phase = NUM_DONE;
      end
      NUM_FRAC: begin
        if (!is_digit) num_phase = NUM_DONE;
        else if (frac_cnt < scp_pkg::KEEP_DIGITS) begin
          frac_num = frac_num * 10 + (c - CH_ZERO);
          frac_cnt++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_visible(input int pos, input logic [7:0] c);
    if (pos == 0) lead_byte = c;
    if (pos >= 5) hello_ok = 0;
    else if (c != HELLO_TEXT[8*(4-pos) +: 8]) hello_ok = 0;
    if (!delim_hit) begin
      if (c == delim_reg) delim_hit = 1;
      return;
    end
    scan_number(c);
  endfunction

  // judge a finished line and queue its reply, if any
  function automatic void judge_line();
    reply_t       r;
    logic [127:0] units;
    logic [63:0]  mag;
    logic [63:0]  limit;
    bit           sat;
    if (line_len == 0) return;
    if (hello_ok && (zero_seen || line_len == 5)) begin
      r.kind      = scp_pkg::KIND_HELLO;
      r.letter    = 8'd0;
      r.value     = '0;
      r.saturated = 1'b0;
      awaited_replies.push_back(r);
      clear_line();
      return;
    end
    if (!delim_hit) begin
      clear_line();
      return;
    end
    units = (frac_num << FRAC_BITS) / ten_to(frac_cnt);
    mag   = (int_mag << FRAC_BITS) + units[63:0];
    limit = 64'd1 << (scp_pkg::VALUE_BITS - 1);
    sat   = 0;
    if (negative) begin
      if (mag > limit) begin
        mag = limit;
        sat = 1;
      end
      mag = 64'd0 - mag;
    end else if (mag > limit - 64'd1) begin
      mag = limit - 64'd1;
      sat = 1;
    end
    r.kind      = scp_pkg::KIND_COMMAND;
    r.letter    = lead_byte;
    r.value     = mag[scp_pkg::VALUE_BITS-1:0];
    r.saturated = sat | int_overflow;
    awaited_replies.push_back(r);
    clear_line();
  endfunction

  // model update for one accepted byte
  function automatic void absorb_byte(input logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      judge_line();
      return;
    end
    if (line_len >= LINE_CAP - 1) begin
      clear_line();
      return;
    end
    if (!zero_seen) begin
      if (c == CH_NUL) begin
        zero_seen = 1;
        if (line_len < 5) hello_ok = 0;
      end else begin
        take_visible(line_len, c);
      end
    end
    line_len++;
  endfunction

  // one byte transfer; called and returns just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    if (gaps_on) burst_left--;
    in_if.valid   = 1'b1;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    absorb_byte(b);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CH_LF);
  endtask

  task automatic wait_drained();
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_delimiter(input logic [7:0] d);
    wait_drained();
    cfg_if.valid          = 1'b1;
    cfg_if.delimiter_char = d;
    do @(posedge clk); while (!cfg_if.ready);
    delim_reg = d;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    return $urandom_range(0, 1) ? CH_LF : CH_CR;
  endfunction

  task automatic send_digits(input int n);
    repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // well-formed command line with random content
  task automatic send_command_line();
    logic [7:0] lead;
    int         n;
    if ($urandom_range(0, 1)) lead = 8'("A" + $urandom_range(0, 25));
    else do lead = 8'($urandom_range(1, 255)); while (lead == CH_LF || lead == CH_CR);
    send_byte(lead);
    send_byte(delim_reg);
    repeat ($urandom_range(0, 2)) send_byte(pick_blank());
    case ($urandom_range(0, 3))
      0:       send_byte(CH_PLUS);
      1:       send_byte(CH_MINUS);
      default: ;
    endcase
    n = $urandom_range(0, 99);
    send_digits(n < 80 ? $urandom_range(0, 5) : n < 95 ? $urandom_range(6, 10)
                : $urandom_range(11, 14));
    if ($urandom_range(0, 9) < 6) begin
      send_byte(CH_POINT);
      send_digits($urandom_range(0, 99) < 85 ? $urandom_range(0, 6) : $urandom_range(7, 26));
    end
    if ($urandom_range(0, 9) == 0) send_byte(CH_NUL);
    if ($urandom_range(0, 6) == 0) send_byte(8'($urandom_range(0, 255)));
    send_byte(pick_terminator());
  endtask

  task automatic send_hello_variant();
    case ($urandom_range(0, 4))
      0: send_text("HELLO");
      1: begin
        send_text("HELLO");
        send_byte(CH_NUL);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      2: send_text("HELL");
      3: begin
        send_text("HELLO");
        send_byte(8'($urandom_range(1, 255)));
      end
      default: begin
        send_text("HELL");
        send_byte(CH_NUL);
      end
    endcase
    send_byte(pick_terminator());
  endtask

  task automatic send_noise_line(input int lo, input int hi, input logic [7:0] min_b,
                                 input logic [7:0] max_b);
    repeat ($urandom_range(lo, hi)) send_byte(8'($urandom_range(min_b, max_b)));
    send_byte(pick_terminator());
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  task automatic test_handshake();
    send_line("HELLO");
    send_text("HELLO");
    send_byte(CH_NUL);
    send_text("zz");
    send_byte(CH_CR);
    send_text("HELL");
    send_byte(CH_NUL);
    send_byte(CH_LF);
    send_line("HELLOX");
    send_byte(CH_LF);
    send_line("hello 1");
  endtask

  task automatic test_number_forms();
    send_line("A 12.5");
    send_line("B -3");
    send_text("C ");
    send_byte(CH_TAB);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_line("+.75");
    send_line("D 2147483647.9999847");
    send_line("E -2147483648");
    send_line("F 2147483648");
    send_line("G 99999999999999");
    send_line("H -");
    send_line("I ");
    send_line("J x5");
    send_line("K 0.12345678901234567890123456");
    send_line("L -0.00001");
    send_line("M 255.255.255");
  endtask

  // a line of exactly 31 characters is judged, a 32nd character drops it
  task automatic test_full_line();
    send_text("N 1.");
    repeat (27) send_byte("5");
    send_byte(CH_LF);
    repeat (31) send_byte("x");
    send_byte("Q");
    send_line(" 7");
  endtask

  task automatic test_zero_byte();
    send_text("K 5");
    send_byte(CH_NUL);
    send_line(" 9");
    send_byte(CH_NUL);
    send_line("A 1");
  endtask

  task automatic test_delimiter_settings();
    set_delimiter(8'd1);
    send_byte("A");
    send_byte(8'd1);
    send_line("3.5");
    send_line("A 3");
    set_delimiter(8'd255);
    send_byte("Z");
    send_byte(8'd255);
    send_line("-7");
    set_delimiter(8'd0);
    send_line("A 1");
    send_byte("A");
    send_byte(CH_NUL);
    send_line("1");
    set_delimiter("=");
    send_line("HELLO");
    send_line("X=42");
    set_delimiter("L");
    send_line("HELLO");
    send_line("QL-1.5");
    set_delimiter(scp_pkg::DELIM_RESET);
  endtask

  // receiver holds off while short commands keep coming
  task automatic test_output_backpressure();
    gaps_on = 0;
    stall_request = HOLD_OFF;
    repeat (20) begin
      send_byte("P");
      send_byte(delim_reg);
      send_digits($urandom_range(1, 3));
      send_byte(CH_LF);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int lines_in_phase;
    int pick;
    int start_bytes;
    lines_in_phase = 0;
    start_bytes = random_bytes_sent;
    while (random_bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (lines_in_phase == 0) begin
        case ($urandom_range(0, 4))
          0:       set_delimiter(scp_pkg::DELIM_RESET);
          1:       set_delimiter(",");
          2:       set_delimiter(":");
          default: set_delimiter(8'($urandom_range(1, 255)));
        endcase
        gaps_on = $urandom_range(0, 3) != 0;
        lines_in_phase = $urandom_range(20, 60);
      end
      lines_in_phase--;
      pick = $urandom_range(0, 99);
      if (pick < 60) send_command_line();
      else if (pick < 68) send_hello_variant();
      else if (pick < 78) send_noise_line(1, 40, 8'd0, 8'd255);
      else if (pick < 83) send_byte(pick_terminator());
      else if (pick < 90) send_noise_line(31, 45, 8'd33, 8'd126);
      else send_noise_line(1, 12, 8'd33, 8'd126);
    end
  endtask

  // count every accepted byte; the random part counts its own from its start value
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) random_bytes_sent++;
  end

  // receiver: stall pattern in windows, plus an on-demand long hold-off
  initial begin : receiver_pattern
    int         hold_left;
    int         window;
    int         mode;
    logic [15:0] pat;
    out_if.ready = 1'b0;
    hold_left = 0;
    window = 0;
    mode = 0;
    pat = '1;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        if (window == 0) begin
          window = $urandom_range(32, 200);
          mode = $urandom_range(0, 2);
          pat = 16'($urandom);
        end
        window--;
        case (mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          default: out_if.ready = pat[window % 16];
        endcase
      end
    end
  end

  // reply check against the oldest expectation
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("reply transfer with nothing expected: kind %0d letter %0d value %0d",
               out_if.result_kind, out_if.command_letter, out_if.command_value);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_if.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_if.result_kind);
          fail_count++;
        end
        if (out_if.command_letter !== want.letter) begin
          $error("command_letter: expected %0d, got %0d", want.letter, out_if.command_letter);
          fail_count++;
        end
        if (out_if.command_value !== want.value) begin
          $error("command_value: expected %0d, got %0d", $signed(want.value),
                 out_if.command_value);
          fail_count++;
        end
        if (out_if.value_saturated !== want.saturated) begin
          $error("value_saturated: expected %0d, got %0d", want.saturated,
                 out_if.value_saturated);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (WATCHDOG) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin
    fail_count = 0;
    random_bytes_sent = 0;
    gaps_on = 1;
    burst_left = 0;
    stall_request = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.delimiter_char = scp_pkg::DELIM_RESET;
    delim_reg = scp_pkg::DELIM_RESET;
    clear_line();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_handshake();
    test_number_forms();
    test_full_line();
    test_zero_byte();
    test_delimiter_settings();
    test_output_backpressure();
    gaps_on = 1;
    test_random_traffic();

    in_if.valid = 1'b0;
    wait_drained();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/scp_pkg.sv
rtl/scp_if.sv
rtl/scp_queue.sv
rtl/scp_front.sv
rtl/scp_back.sv
rtl/serial_command_line_parser_core.sv
tb/serial_command_line_parser_core_test.sv
